// ===== src/lenorm_pkg.sv =====
// ----------------------------------------------------------------------------
// Line ending normaliser package
// Shared types, codes and helper functions for the normaliser and its
// result queue.
// ----------------------------------------------------------------------------
`default_nettype none

package lenorm_pkg;

    localparam int unsigned CODE_W = 32;
    localparam int unsigned LINE_W = 24;
    localparam int unsigned COL_W  = 16;
    localparam int unsigned MODE_W = 2;
    localparam int unsigned IDX_W  = 2;

    localparam logic [LINE_W-1:0] LINE_MAX = '1;
    localparam logic [COL_W-1:0]  COL_MAX  = '1;

    localparam logic [CODE_W-1:0] LF_B0 = 32'h0000_000a;
    localparam logic [CODE_W-1:0] LF_B1 = 32'h0000_0a00;
    localparam logic [CODE_W-1:0] LF_B3 = 32'h0a00_0000;
    localparam logic [CODE_W-1:0] CR_B0 = 32'h0000_000d;
    localparam logic [CODE_W-1:0] CR_B1 = 32'h0000_0d00;
    localparam logic [CODE_W-1:0] CR_B3 = 32'h0d00_0000;

    localparam logic [MODE_W-1:0] MODE_BOTH = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CRLF = 2'd1;
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd2;

    localparam logic [IDX_W-1:0] REG_BREAK_CODE = 2'd0;
    localparam logic [IDX_W-1:0] REG_MERGE_MODE = 2'd1;
    localparam logic [IDX_W-1:0] REG_START_LINE = 2'd2;
    localparam logic [IDX_W-1:0] REG_START_COL  = 2'd3;

    localparam logic [CODE_W-1:0] RST_BREAK_CODE = 32'd10;
    localparam logic [MODE_W-1:0] RST_MERGE_MODE = MODE_CRLF;
    localparam logic [LINE_W-1:0] RST_START_LINE = 24'd1;
    localparam logic [COL_W-1:0]  RST_START_COL  = 16'd0;

    typedef struct packed {
        logic [LINE_W-1:0] line;
        logic [COL_W-1:0]  col;
    } t_pos;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        t_pos              pos;
        logic              brk;
        logic              eot;
        logic              last;
    } t_result;

    typedef struct packed {
        t_result [1:0] res;
        logic          two;
    } t_run;

    function automatic logic is_lf(input logic [CODE_W-1:0] c);
        return (c == LF_B0) || (c == LF_B1) || (c == LF_B3);
    endfunction

    function automatic logic is_cr(input logic [CODE_W-1:0] c);
        return (c == CR_B0) || (c == CR_B1) || (c == CR_B3);
    endfunction

    // position of the next emitted result
    function automatic t_pos step_pos(input t_pos p, input logic prev_brk);
        t_pos q;
        q = p;
        if (p.col != COL_MAX) begin
            q.col = p.col + 1'b1;
        end
        if (prev_brk) begin
            if (p.line != LINE_MAX) begin
                q.line = p.line + 1'b1;
            end
            q.col = COL_W'(1);
        end
        return q;
    endfunction

endpackage

`default_nettype wire

// ===== src/lenorm_runq.sv =====
// ----------------------------------------------------------------------------
// Line ending normaliser result queue
// Two-deep queue of result runs (one or two results each), drained one
// result per transfer on the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module lenorm_runq
    import lenorm_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_run    i_run,
    output logic         o_full,
    output logic         o_valid,
    input  wire logic    i_stall,
    output t_result      o_res
);

    t_run       r_runs [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       r_sub;

    logic       pop_res;
    logic       run_done;
    logic       pop_run;

    assign o_full   = (r_cnt == 2'd2);
    assign o_valid  = (r_cnt != 2'd0);
    assign o_res    = r_runs[r_rd].res[r_sub];
    assign pop_res  = o_valid && !i_stall;
    assign run_done = !r_runs[r_rd].two || r_sub;
    assign pop_run  = pop_res && run_done;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_runs[r_wr] <= i_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
            r_sub <= 1'b0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (pop_run) begin
                r_rd  <= !r_rd;
                r_sub <= 1'b0;
            end else if (pop_res) begin
                r_sub <= 1'b1;
            end
            case ({i_push, pop_run})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== src/line_ending_normalizer_with_position_top.sv =====
// ----------------------------------------------------------------------------
// Line ending normaliser with line and column tracking
// Input channel: i_in_valid / o_in_stall with char_code and end_of_text.
// Output channel: o_out_valid / i_out_stall with the tagged result fields.
// Each character is passed on with its line and column; CR, LF and the
// merged pairs chosen by merge_mode become r_break_code. A break that may
// start a pair is held back until the next item; an end item flushes it and
// then gives an end marker, and reloads the counters for a new stream.
// Each result is registered in the run queue before it is offered.
// Throughput: one input item per cycle while o_in_stall is low; an item giving
// two results leaves as two output transfers through the single output port of the two-run queue.
// Items giving no result only update the state.
// Reset (synchronous, active low) loads the register defaults, clears any
// held break and empties the queue. When the receiver stalls, the queue
// fills and o_in_stall rises once two runs are waiting.
// Configuration writes are taken at any edge with i_cfg_we high outside reset.
// ----------------------------------------------------------------------------
`default_nettype none

module line_ending_normalizer_with_position_top
    import lenorm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CODE_W-1:0] i_cfg_data,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [CODE_W-1:0] i_char_code,
    input  wire logic              i_end_of_text,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [CODE_W-1:0]      o_out_code,
    output logic [LINE_W-1:0]      o_line_number,
    output logic [COL_W-1:0]       o_column_number,
    output logic                   o_is_break,
    output logic                   o_is_end,
    output logic                   o_last_of_run
);

    logic [CODE_W-1:0] r_break_code;
    logic [MODE_W-1:0] r_mode;
    logic [LINE_W-1:0] r_start_line;
    logic [COL_W-1:0]  r_start_col;

    logic              r_held;
    logic              r_held_cr;
    t_pos              r_pos;
    logic              r_prev;

    logic              n_held;
    logic              n_held_cr;
    t_pos              n_pos;
    logic              n_prev;

    logic              accept;
    logic              q_full;
    t_run              run;
    logic [1:0]        n_res;
    t_result           res_q;

    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    always_comb begin
        logic    c_lf;
        logic    c_cr;
        logic    pair;
        logic    proc;
        logic    hold;
        logic    unit_emit;
        t_pos    p;
        logic    prev;
        t_result r;

        c_lf = is_lf(i_char_code);
        c_cr = is_cr(i_char_code);
        pair = !i_end_of_text && r_held && (r_held_cr ? c_lf : c_cr);
        proc = !i_end_of_text && !pair;
        hold = (c_lf && (r_mode == MODE_BOTH)) || (c_cr && (r_mode != MODE_NONE));
        unit_emit = proc && !hold;

        p       = r_pos;
        prev    = r_prev;
        r       = '0;
        n_res   = 2'd0;
        run     = '0;
        n_held    = r_held;
        n_held_cr = r_held_cr;

        if (r_held) begin
            p = step_pos(p, prev);
            r = '{code: r_break_code, pos: p, brk: 1'b1, eot: 1'b0, last: 1'b0};
            run.res[0] = r;
            prev  = 1'b1;
            n_res = 2'd1;
        end
        if (unit_emit) begin
            p = step_pos(p, prev);
            r.code = (c_lf || c_cr) ? r_break_code : i_char_code;
            r.pos  = p;
            r.brk  = c_lf || c_cr;
            r.eot  = 1'b0;
            r.last = 1'b0;
            run.res[n_res[0]] = r;
            prev  = c_lf || c_cr;
            n_res = n_res + 2'd1;
        end
        if (i_end_of_text) begin
            r = '{code: '0, pos: p, brk: 1'b0, eot: 1'b1, last: 1'b0};
            run.res[n_res[0]] = r;
            n_res = n_res + 2'd1;
            n_pos     = '{line: r_start_line, col: r_start_col};
            n_prev    = 1'b0;
            n_held    = 1'b0;
            n_held_cr = 1'b0;
        end else begin
            n_pos  = p;
            n_prev = prev;
            n_held = proc && hold;
            if (proc && hold) begin
                n_held_cr = c_cr;
            end
        end

        run.two = (n_res == 2'd2);
        if (n_res == 2'd2) begin
            run.res[1].last = 1'b1;
        end else begin
            run.res[0].last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_break_code <= RST_BREAK_CODE;
            r_mode       <= RST_MERGE_MODE;
            r_start_line <= RST_START_LINE;
            r_start_col  <= RST_START_COL;
            r_held       <= 1'b0;
            r_held_cr    <= 1'b0;
            r_pos        <= '{line: RST_START_LINE, col: RST_START_COL};
            r_prev       <= 1'b0;
        end else begin
            if (accept) begin
                r_held    <= n_held;
                r_held_cr <= n_held_cr;
                r_pos     <= n_pos;
                r_prev    <= n_prev;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_BREAK_CODE: r_break_code <= i_cfg_data;
                    REG_MERGE_MODE: r_mode <= i_cfg_data[MODE_W-1:0];
                    REG_START_LINE: begin
                        r_start_line <= i_cfg_data[LINE_W-1:0];
                        r_pos.line   <= i_cfg_data[LINE_W-1:0];
                    end
                    REG_START_COL: begin
                        r_start_col <= i_cfg_data[COL_W-1:0];
                        r_pos.col   <= i_cfg_data[COL_W-1:0];
                    end
                    default: r_mode <= r_mode;
                endcase
            end
        end
    end

    lenorm_runq u_runq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && (n_res != 2'd0)),
        .i_run   (run),
        .o_full  (q_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_res   (res_q)
    );

    assign o_out_code      = res_q.code;
    assign o_line_number   = res_q.pos.line;
    assign o_column_number = res_q.pos.col;
    assign o_is_break      = res_q.brk;
    assign o_is_end        = res_q.eot;
    assign o_last_of_run   = res_q.last;

endmodule

`default_nettype wire
